### rtl/core/msdr_pkg.sv
// Shared types and constants for the mode switch disparity ramp block.
// No dependencies; every other file in rtl/core imports this package.
package msdr_pkg;

    localparam int DISPARITY_WIDTH_DEF    = 16;
    localparam int POSITION_FRAC_BITS_DEF = 16;

    localparam int DURATION_W  = 24;
    localparam int EASING_W    = 2;
    localparam int MODE_W      = 8;
    localparam int VIEWS_W     = 8;
    localparam int TICK_W      = 20;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = DURATION_W;

    localparam logic [VIEWS_W-1:0] MONO_MAX_VIEWS = VIEWS_W'(1);

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EASING   = 1'b1;

    localparam logic [EASING_W-1:0] EASE_LINEAR = 2'd0;
    localparam logic [EASING_W-1:0] EASE_CUBIC  = 2'd1;
    localparam logic [EASING_W-1:0] EASE_SMOOTH = 2'd2;

    typedef struct packed {
        logic [DURATION_W-1:0] duration;
        logic [EASING_W-1:0]   easing;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_FIRE_UP   = 2'd1,
        PH_DOWN_FIRE = 2'd2
    } phase_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_WAIT,
        ST_EASE,
        ST_MUL1_WAIT,
        ST_MUL2_WAIT,
        ST_LERP,
        ST_LERP_WAIT,
        ST_EMIT
    } seq_state_t;

endpackage

### rtl/core/msdr_if.sv
// Channel interfaces of the mode switch disparity ramp block:
// request/tick items in, results out, configuration writes. Uses msdr_pkg.
interface msdr_in_if
    import msdr_pkg::*;
#(
    parameter int DISPARITY_WIDTH = DISPARITY_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [MODE_W-1:0]                 target_mode;
    logic [VIEWS_W-1:0]                target_view_count;
    logic [MODE_W-1:0]                 current_mode;
    logic [VIEWS_W-1:0]                current_view_count;
    logic signed [DISPARITY_WIDTH-1:0] current_disparity;
    logic signed [DISPARITY_WIDTH-1:0] steady_disparity;
    logic [TICK_W-1:0]                 tick_time_us;

    modport source (
        output valid, cmd, target_mode, target_view_count, current_mode,
               current_view_count, current_disparity, steady_disparity, tick_time_us,
        input  ready
    );
    modport sink (
        input  valid, cmd, target_mode, target_view_count, current_mode,
               current_view_count, current_disparity, steady_disparity, tick_time_us,
        output ready
    );
endinterface

interface msdr_out_if
    import msdr_pkg::*;
#(
    parameter int DISPARITY_WIDTH = DISPARITY_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [DISPARITY_WIDTH-1:0] disparity;
    logic                              fire;
    logic [MODE_W-1:0]                 mode;

    modport source (output valid, disparity, fire, mode, input ready);
    modport sink (input valid, disparity, fire, mode, output ready);
endinterface

interface msdr_cfg_if
    import msdr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/msdr_alu.sv
// Shared shift-add multiplier / restoring divider, one bit per cycle.
// A single adder serves both operations. Uses msdr_pkg.
module msdr_alu
    import msdr_pkg::*;
#(
    parameter int UW        = 36,
    parameter int MUL_STEPS = 18,
    parameter int DIV_STEPS = 36
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  alu_op_t       op,
    input  logic [UW-1:0] opa,
    input  logic [UW-1:0] opb,
    output logic          busy,
    output logic          done,
    output logic [UW-1:0] result
);

    localparam int MAX_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
    localparam int CW        = $clog2(MAX_STEPS + 1);

    logic [UW-1:0] acc_reg, acc_next;
    logic [UW-1:0] a_reg, a_next;
    logic [UW-1:0] b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    alu_op_t       op_reg, op_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [UW-1:0] rem_sh;
    logic [UW-1:0] add_x;
    logic [UW-1:0] add_y;
    logic [UW:0]   sum;
    logic          is_div;
    logic          geq;

    always_comb
    begin
        is_div = (op_reg == ALU_DIV);
        // divider: bring down the next numerator bit, try to subtract
        rem_sh = {acc_reg[UW-2:0], a_reg[DIV_STEPS-1]};
        add_x  = is_div ? rem_sh : acc_reg;
        add_y  = is_div ? ~b_reg : (b_reg[0] ? a_reg : '0);
        sum    = {1'b0, add_x} + {1'b0, add_y} + {{UW{1'b0}}, is_div};
        geq    = sum[UW];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            acc_next  = '0;
            a_next    = opa;
            b_next    = opb;
            op_next   = op;
            cnt_next  = (op == ALU_DIV) ? CW'(DIV_STEPS) : CW'(MUL_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (is_div)
            begin
                acc_next = geq ? sum[UW-1:0] : rem_sh;
                a_next   = {a_reg[UW-2:0], geq};
            end
            else
            begin
                acc_next = sum[UW-1:0];
                a_next   = {a_reg[UW-2:0], 1'b0};
                b_next   = {1'b0, b_reg[UW-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    // quotient collects in the low bits of a_reg
    assign result = is_div ? a_reg : acc_reg;

endmodule

### rtl/core/msdr_cfg_regs.sv
// Configuration registers: ramp duration and easing curve.
// Written through the configuration channel; uses msdr_pkg and msdr_cfg_if.
module msdr_cfg_regs
    import msdr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    msdr_cfg_if.sink        wr,
    output cfg_t            regs
);

    cfg_t regs_reg, regs_next;

    assign wr.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr.valid)
        begin
            unique case (wr.index)
                CFG_DURATION: regs_next.duration = wr.data[DURATION_W-1:0];
                CFG_EASING:   regs_next.easing   = wr.data[EASING_W-1:0];
                default:      regs_next          = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.duration <= '0;
            regs_reg.easing   <= EASE_SMOOTH;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

### rtl/core/msdr_seq.sv
// Sequencer of the mode switch: ramp state, position advance, easing and
// interpolation steps issued to the shared unit, output register. Uses msdr_pkg.
module msdr_seq
    import msdr_pkg::*;
#(
    parameter int DISPARITY_WIDTH    = DISPARITY_WIDTH_DEF,
    parameter int POSITION_FRAC_BITS = POSITION_FRAC_BITS_DEF,
    parameter int UW                 = 36
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    msdr_in_if.sink       item,
    msdr_out_if.source    result,
    output logic          alu_start,
    output alu_op_t       alu_op,
    output logic [UW-1:0] alu_a,
    output logic [UW-1:0] alu_b,
    input  logic          alu_busy,
    input  logic          alu_done,
    input  logic [UW-1:0] alu_result
);

    localparam int DW = DISPARITY_WIDTH;
    localparam int FB = POSITION_FRAC_BITS;
    localparam int NW = TICK_W + FB;
    localparam int PL = DW + FB + 2;
    localparam int QW = PL - FB;
    localparam logic [FB:0]   POS_ONE   = {1'b1, {FB{1'b0}}};
    localparam logic [FB+1:0] POS_THREE = {2'b11, {FB{1'b0}}};

    seq_state_t state_reg, state_next;

    phase_t            phase_reg, phase_next;
    logic [DW-1:0]     start_reg, start_next;
    logic [DW-1:0]     end_reg, end_next;
    logic [FB:0]       pos_reg, pos_next;
    logic [DW-1:0]     disp_reg, disp_next;
    logic              fire_pending_reg, fire_pending_next;
    logic              fire_at_end_reg, fire_at_end_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [FB:0]       e_reg, e_next;
    logic              fire_reg, fire_next;
    logic              out_valid_reg, out_valid_next;
    logic [DW-1:0]     out_disp_reg, out_disp_next;
    logic              out_fire_reg, out_fire_next;
    logic [MODE_W-1:0] out_mode_reg, out_mode_next;

    logic          item_acc;
    logic          is_tick;
    logic          is_req;
    logic          pos_full;
    logic          pos_zero;
    logic          need_div;
    logic          ease_simple;
    logic          ease_cubic;
    logic          out_free;
    logic          to_mono;
    logic          from_mono;
    logic [FB:0]   u_val;
    logic [FB+1:0] three_minus;
    logic [FB:0]   mid;
    logic [NW:0]   pos_sum;
    logic [DW:0]   diff;
    logic [DW:0]   mag;
    logic [PL-1:0] prod;
    logic [PL-1:0] prod_up;
    logic [QW-1:0] q_val;
    logic [QW-1:0] delta;
    logic [QW-1:0] lerp_sum;

    assign item_acc    = item.valid && item.ready;
    assign is_tick     = (item.cmd == CMD_TICK);
    assign is_req      = (item.cmd == CMD_REQUEST);
    assign pos_full    = pos_reg[FB];
    assign pos_zero    = (pos_reg == '0);
    assign need_div    = !pos_full && (cfg.duration != '0);
    assign ease_cubic  = (cfg.easing == EASE_CUBIC);
    assign ease_simple = pos_zero || pos_full || (cfg.easing == EASE_LINEAR);
    assign out_free    = !out_valid_reg || result.ready;
    assign to_mono     = (item.target_view_count <= MONO_MAX_VIEWS);
    assign from_mono   = (item.current_view_count <= MONO_MAX_VIEWS);

    assign u_val       = POS_ONE - pos_reg;
    assign three_minus = POS_THREE - {pos_reg, 1'b0};
    assign mid         = alu_result[FB +: FB+1];
    assign pos_sum     = (NW+1)'(pos_reg) + {1'b0, alu_result[NW-1:0]};

    assign diff     = {end_reg[DW-1], end_reg} - {start_reg[DW-1], start_reg};
    assign mag      = diff[DW] ? (~diff + 1'b1) : diff;
    assign prod     = alu_result[PL-1:0];
    // round the magnitude up so a negative step floors toward minus infinity
    assign prod_up  = prod + PL'({FB{1'b1}});
    assign q_val    = diff[DW] ? prod_up[PL-1:FB] : prod[PL-1:FB];
    assign delta    = diff[DW] ? (~q_val + 1'b1) : q_val;
    assign lerp_sum = {{(QW-DW){start_reg[DW-1]}}, start_reg} + delta;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && is_tick)
                begin
                    if (phase_reg == PH_IDLE)
                        state_next = ST_EMIT;
                    else if (need_div)
                        state_next = ST_DIV_WAIT;
                    else
                        state_next = ST_EASE;
                end
            end
            ST_DIV_WAIT:  if (alu_done) state_next = ST_EASE;
            ST_EASE:      state_next = ease_simple ? ST_LERP : ST_MUL1_WAIT;
            ST_MUL1_WAIT: if (alu_done) state_next = ST_MUL2_WAIT;
            ST_MUL2_WAIT: if (alu_done) state_next = ST_LERP;
            ST_LERP:      state_next = ST_LERP_WAIT;
            ST_LERP_WAIT: if (alu_done) state_next = ST_EMIT;
            ST_EMIT:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and shared unit requests
    always_comb
    begin
        item.ready = 1'b0;
        alu_start  = 1'b0;
        alu_op     = ALU_MUL;
        alu_a      = '0;
        alu_b      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item_acc && is_tick && (phase_reg != PH_IDLE) && need_div)
                begin
                    alu_start = 1'b1;
                    alu_op    = ALU_DIV;
                    alu_a     = UW'(item.tick_time_us) << FB;
                    alu_b     = UW'(cfg.duration);
                end
            end
            ST_EASE:
            begin
                if (!ease_simple)
                begin
                    alu_start = 1'b1;
                    alu_a     = ease_cubic ? UW'(u_val) : UW'(pos_reg);
                    alu_b     = ease_cubic ? UW'(u_val) : UW'(pos_reg);
                end
            end
            ST_MUL1_WAIT:
            begin
                if (alu_done)
                begin
                    alu_start = 1'b1;
                    alu_a     = UW'(mid);
                    alu_b     = ease_cubic ? UW'(u_val) : UW'(three_minus);
                end
            end
            ST_LERP:
            begin
                alu_start = 1'b1;
                alu_a     = UW'(mag);
                alu_b     = UW'(e_reg);
            end
            ST_DIV_WAIT, ST_MUL2_WAIT, ST_LERP_WAIT, ST_EMIT:
            begin
                alu_start = 1'b0;
            end
            default:
            begin
                alu_start = 1'b0;
            end
        endcase
    end

    // datapath and ramp state
    always_comb
    begin
        phase_next        = phase_reg;
        start_next        = start_reg;
        end_next          = end_reg;
        pos_next          = pos_reg;
        disp_next         = disp_reg;
        fire_pending_next = fire_pending_reg;
        fire_at_end_next  = fire_at_end_reg;
        mode_next         = mode_reg;
        e_next            = e_reg;
        fire_next         = fire_reg;
        out_disp_next     = out_disp_reg;
        out_fire_next     = out_fire_reg;
        out_mode_next     = out_mode_reg;
        out_valid_next    = (out_valid_reg && !result.ready);

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && is_req)
                begin
                    // a new request replaces any ramp in flight
                    mode_next  = item.target_mode;
                    start_next = item.current_disparity;
                    if (to_mono && !from_mono)
                    begin
                        phase_next        = PH_DOWN_FIRE;
                        end_next          = '0;
                        fire_at_end_next  = 1'b1;
                        fire_pending_next = 1'b0;
                    end
                    else if (!to_mono && from_mono)
                    begin
                        phase_next        = PH_FIRE_UP;
                        start_next        = '0;
                        end_next          = item.steady_disparity;
                        fire_pending_next = 1'b1;
                        fire_at_end_next  = 1'b0;
                    end
                    else
                    begin
                        phase_next        = PH_FIRE_UP;
                        end_next          = to_mono ? item.current_disparity
                                                    : item.steady_disparity;
                        fire_pending_next = (item.target_mode != item.current_mode);
                        fire_at_end_next  = 1'b0;
                    end
                    pos_next  = (cfg.duration != '0) ? '0 : POS_ONE;
                    disp_next = start_next;
                end
                else if (item_acc && is_tick)
                begin
                    fire_next = 1'b0;
                    if ((phase_reg != PH_IDLE) && !need_div)
                        pos_next = POS_ONE;
                end
            end
            ST_DIV_WAIT:
            begin
                if (alu_done)
                    pos_next = (pos_sum > (NW+1)'(POS_ONE)) ? POS_ONE : pos_sum[FB:0];
            end
            ST_EASE:
            begin
                // zero, full and linear positions pass through unchanged
                if (ease_simple)
                    e_next = pos_reg;
            end
            ST_MUL2_WAIT:
            begin
                if (alu_done)
                    e_next = ease_cubic ? (POS_ONE - mid) : mid;
            end
            ST_LERP_WAIT:
            begin
                if (alu_done)
                begin
                    disp_next = lerp_sum[DW-1:0];
                    fire_next = 1'b0;
                    case (phase_reg)
                        PH_FIRE_UP:
                        begin
                            fire_next         = fire_pending_reg;
                            fire_pending_next = 1'b0;
                            if (pos_full)
                                phase_next = PH_IDLE;
                        end
                        PH_DOWN_FIRE:
                        begin
                            if (pos_full)
                            begin
                                fire_next        = fire_at_end_reg;
                                fire_at_end_next = 1'b0;
                                phase_next       = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_disp_next  = disp_reg;
                    out_fire_next  = fire_reg;
                    out_mode_next  = mode_reg;
                end
            end
            default:
            begin
                e_next = e_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_IDLE;
            start_reg        <= '0;
            end_reg          <= '0;
            pos_reg          <= '0;
            disp_reg         <= '0;
            fire_pending_reg <= 1'b0;
            fire_at_end_reg  <= 1'b0;
            mode_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            start_reg        <= start_next;
            end_reg          <= end_next;
            pos_reg          <= pos_next;
            disp_reg         <= disp_next;
            fire_pending_reg <= fire_pending_next;
            fire_at_end_reg  <= fire_at_end_next;
            mode_reg         <= mode_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        fire_reg     <= fire_next;
        out_disp_reg <= out_disp_next;
        out_fire_reg <= out_fire_next;
        out_mode_reg <= out_mode_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.disparity = out_disp_reg;
    assign result.fire      = out_fire_reg;
    assign result.mode      = out_mode_reg;

`ifndef SYNTHESIS
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_ONE)
        else $error("ramp position above one");

    a_fire_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire_pending_reg && fire_at_end_reg))
        else $error("both fire flags armed");

    a_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_start |-> !alu_busy)
        else $error("shared unit started while busy");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_valid_reg && !result.ready
        |=> (state_reg == ST_EMIT))
        else $error("result dropped while output stalled");
`endif

endmodule

### rtl/core/mode_switch_disparity_ramp_top.sv
// Mode switch disparity ramp: 2D/3D mode change sequencer with eased ramp.
// Channels: item (request or tick in), result (one item per tick out),
// cfg (register writes: 0 ramp duration in us, 1 easing curve; always ready).
// A request gives no result. A tick while no ramp runs goes to the emit
// state and from there into the output register. A tick during a ramp
// runs on one shared shift-add/subtract unit, one bit per cycle: a
// (20 + POSITION_FRAC_BITS)-step division for the position advance (skipped
// when the position is already one or the duration is zero), up to two
// (POSITION_FRAC_BITS + 2)-step multiplies for the easing curve and one more
// for the interpolation.
// The item channel is ready only between items; one item is worked on at a time.
// The result sits in an output register; while the receiver stalls the next
// item is still taken and worked on, and it waits at its end for the register.
// Reset clears the ramp state to idle with zero disparity and mode,
// duration 0 and easing smoothstep.
// Depends on msdr_pkg, msdr_if, msdr_alu, msdr_cfg_regs and msdr_seq.
module mode_switch_disparity_ramp_top
    import msdr_pkg::*;
#(
    parameter int DISPARITY_WIDTH    = DISPARITY_WIDTH_DEF,
    parameter int POSITION_FRAC_BITS = POSITION_FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    msdr_in_if.sink    item,
    msdr_out_if.source result,
    msdr_cfg_if.sink   cfg
);

    localparam int FB        = POSITION_FRAC_BITS;
    localparam int DIV_STEPS = TICK_W + FB;
    localparam int MUL_STEPS = FB + 2;
    localparam int EASE_PW   = 2 * FB + 4;
    localparam int LERP_PW   = DISPARITY_WIDTH + FB + 2;
    localparam int PW_MAX    = (EASE_PW > LERP_PW) ? EASE_PW : LERP_PW;
    localparam int UW        = (PW_MAX > DIV_STEPS) ? PW_MAX : DIV_STEPS;

    cfg_t          cfg_q;
    logic          alu_start;
    alu_op_t       alu_op;
    logic [UW-1:0] alu_a;
    logic [UW-1:0] alu_b;
    logic          alu_busy;
    logic          alu_done;
    logic [UW-1:0] alu_result;

    msdr_cfg_regs u_cfg (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (cfg),
        .regs (cfg_q)
    );

    msdr_alu #(
        .UW       (UW),
        .MUL_STEPS(MUL_STEPS),
        .DIV_STEPS(DIV_STEPS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alu_start),
        .op    (alu_op),
        .opa   (alu_a),
        .opb   (alu_b),
        .busy  (alu_busy),
        .done  (alu_done),
        .result(alu_result)
    );

    msdr_seq #(
        .DISPARITY_WIDTH   (DISPARITY_WIDTH),
        .POSITION_FRAC_BITS(POSITION_FRAC_BITS),
        .UW                (UW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .item      (item),
        .result    (result),
        .alu_start (alu_start),
        .alu_op    (alu_op),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_busy  (alu_busy),
        .alu_done  (alu_done),
        .alu_result(alu_result)
    );

endmodule
